@@ src/vrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, constants and helpers for the vector rect/polar unit.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // default parameter values
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // internal formats
    localparam int CW        = 52;   // cordic x/y width
    localparam int ZW        = 44;   // cordic angle width (degrees, Q30)
    localparam int ANG_FRAC  = 30;
    localparam int GUARD     = 16;
    localparam int MAX_STEPS = 32;

    localparam logic [31:0]          INV_GAIN   = 32'd2608131496;
    localparam logic signed [ZW-1:0] DEG180_Q30 = 44'sd193273528320;
    localparam logic signed [ZW-1:0] DEG90_Q30  = 44'sd96636764160;

    // operation codes
    localparam logic [2:0] MODE_RECT  = 3'd0;
    localparam logic [2:0] MODE_POLAR = 3'd1;
    localparam logic [2:0] MODE_ADD   = 3'd2;
    localparam logic [2:0] MODE_SUB   = 3'd3;
    localparam logic [2:0] MODE_NEG   = 3'd4;
    localparam logic [2:0] MODE_SCALE = 3'd5;

    // cordic datapath word
    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [ZW-1:0] z;
    } cor_t;

    // sideband carried alongside the cordic word
    typedef struct packed {
        logic               rot;    // rotation (polar build) vs vectoring
        logic               flip;   // rotation result is negated
        logic               zero;   // vectoring input is the zero vector
        logic               polar;
        logic               sat;
        logic               bad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        mag;
        logic signed [24:0] ang;
    } side_t;

    // arctangent of 2^-i in degrees, Q30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 44'sd48318382080;
            1:  r = 44'sd28524006506;
            2:  r = 44'sd15071301663;
            3:  r = 44'sd7650427850;
            4:  r = 44'sd3840059795;
            5:  r = 44'sd1921901881;
            6:  r = 44'sd961185452;
            7:  r = 44'sd480622056;
            8:  r = 44'sd240314695;
            9:  r = 44'sd120157806;
            10: r = 44'sd60078960;
            11: r = 44'sd30039487;
            12: r = 44'sd15019745;
            13: r = 44'sd7509872;
            14: r = 44'sd3754936;
            15: r = 44'sd1877468;
            16: r = 44'sd938734;
            17: r = 44'sd469367;
            18: r = 44'sd234684;
            19: r = 44'sd117342;
            20: r = 44'sd58671;
            21: r = 44'sd29335;
            22: r = 44'sd14668;
            23: r = 44'sd7334;
            24: r = 44'sd3667;
            25: r = 44'sd1833;
            26: r = 44'sd917;
            27: r = 44'sd458;
            28: r = 44'sd229;
            29: r = 44'sd115;
            30: r = 44'sd57;
            31: r = 44'sd29;
            default: r = '0;
        endcase
        return r;
    endfunction

    // clip to the signed 32-bit range; bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

@@ src/vector_rect_polar_unit_core.sv @@
// ----------------------------------------------------------------------------
// vector_rect_polar_unit_core
// CORDIC_STEPS is capped at 32. Throughput: one item per cycle while the
// output is not stalled by m_ready.
// One register stage per CORDIC iteration, plus three stages of operand
// work ahead of it and two stages of rounding and gain correction after it.
// Reset clears all valid bits; the pipeline stalls as a whole on m_ready.
// ----------------------------------------------------------------------------
// Two-dimensional vector operations in fixed point with both rectangular
// and polar forms of every result, magnitude and angle from a CORDIC.
// ----------------------------------------------------------------------------
module vector_rect_polar_unit_core
    import vrp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [31:0] s_op_a,
    input  logic signed [24:0] s_op_b,
    input  logic signed [31:0] s_second_x,
    input  logic signed [31:0] s_second_y,
    input  logic signed [31:0] s_factor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_x,
    output logic signed [31:0] m_res_y,
    output logic [31:0]        m_magnitude,
    output logic signed [24:0] m_angle_deg,
    output logic               m_polar_form,
    output logic               m_saturated,
    output logic               m_bad_mode
);

    localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic signed [ZW-1:0] D180 = ZW'(180) <<< FRAC_BITS;
    localparam logic signed [63:0]   RND_F = 64'sd1 <<< (FRAC_BITS - 1);
    localparam int ZSH = ANG_FRAC - FRAC_BITS;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------- stage 1
    logic               v1_reg;
    logic [2:0]         mode1_reg;
    logic signed [32:0] x33_reg, y33_reg;
    logic signed [63:0] fa_reg, fb_reg;
    logic [62:0]        mg_reg;
    logic [30:0]        m1_reg;
    logic signed [ZW-1:0] w1_reg;

    logic signed [32:0] a33, b33, sx33, sy33, x33_next, y33_next;
    logic [30:0]        m_next;
    logic signed [ZW-1:0] bw, w_next;

    // operand sums, differences and negation, magnitude clamp, angle wrap
    always_comb begin
        a33  = {s_op_a[31], s_op_a};
        b33  = 33'(s_op_b);
        sx33 = {s_second_x[31], s_second_x};
        sy33 = {s_second_y[31], s_second_y};
        case (s_mode)
            MODE_RECT: begin x33_next = a33;        y33_next = b33;        end
            MODE_ADD:  begin x33_next = a33 + sx33; y33_next = b33 + sy33; end
            MODE_SUB:  begin x33_next = a33 - sx33; y33_next = b33 - sy33; end
            MODE_NEG:  begin x33_next = -a33;       y33_next = -b33;       end
            default:   begin x33_next = '0;         y33_next = '0;         end
        endcase
        m_next = s_op_a[31] ? '0 : s_op_a[30:0];
        bw     = ZW'(s_op_b);
        if (bw > D180) begin
            w_next = bw - (D180 <<< 1);
        end else if (bw < -D180) begin
            w_next = bw + (D180 <<< 1);
        end else begin
            w_next = bw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= s_mode;
            x33_reg   <= x33_next;
            y33_reg   <= y33_next;
            fa_reg    <= 64'(s_factor) * 64'(s_op_a);
            fb_reg    <= 64'(s_factor) * 64'(s_op_b);
            mg_reg    <= 63'(m_next) * 63'(INV_GAIN);
            m1_reg    <= m_next;
            w1_reg    <= w_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic  v2_reg;
    side_t side2_reg, side2_next;
    cor_t  rot2_reg, rot2_next;

    logic signed [63:0] rx, ry;
    logic [32:0]        sx, sy;
    logic signed [ZW-1:0] z0;

    // saturate, scale rounding, rotation seed
    always_comb begin
        rx = (fa_reg + RND_F) >>> FRAC_BITS;
        ry = (fb_reg + RND_F) >>> FRAC_BITS;
        if (mode1_reg != MODE_SCALE) begin
            rx = 64'(x33_reg);
            ry = 64'(y33_reg);
        end
        sx = sat32(rx);
        sy = sat32(ry);
        side2_next       = '0;
        side2_next.bad   = (mode1_reg > MODE_SCALE);
        side2_next.polar = (mode1_reg == MODE_POLAR);
        side2_next.rot   = side2_next.polar;
        if (!side2_next.polar && !side2_next.bad) begin
            side2_next.x   = sx[31:0];
            side2_next.y   = sy[31:0];
            side2_next.sat = sx[32] | sy[32];
        end
        side2_next.mag = 32'(m1_reg);
        side2_next.ang = (m1_reg == '0) ? '0 : w1_reg[24:0];
        z0 = w1_reg <<< ZSH;
        rot2_next.px = CW'(mg_reg >> (32 - GUARD));
        rot2_next.py = '0;
        rot2_next.z  = z0;
        if (z0 > DEG90_Q30) begin
            rot2_next.z     = z0 - DEG180_Q30;
            side2_next.flip = 1'b1;
        end else if (z0 < -DEG90_Q30) begin
            rot2_next.z     = z0 + DEG180_Q30;
            side2_next.flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            rot2_reg  <= rot2_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic  v3_reg;
    side_t side3_reg, side3_next;
    cor_t  cor3_reg, cor3_next;

    logic signed [CW-1:0] vx, vy;

    // vectoring seed: move left half-plane vectors to the right
    always_comb begin
        side3_next      = side2_reg;
        side3_next.zero = (side2_reg.x == '0) && (side2_reg.y == '0);
        vx = CW'(side2_reg.x) <<< GUARD;
        vy = CW'(side2_reg.y) <<< GUARD;
        cor3_next.z = '0;
        if (vx < 0) begin
            cor3_next.z = (vy >= 0) ? DEG180_Q30 : -DEG180_Q30;
            vx = -vx;
            vy = -vy;
        end
        cor3_next.px = vx;
        cor3_next.py = vy;
        if (side2_reg.rot) begin
            cor3_next = rot2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg <= side3_next;
            cor3_reg  <= cor3_next;
        end
    end

    // ---------------------------------------------------------- cordic stages
    logic  vc_reg   [NSTEP+1];
    side_t sidec_reg[NSTEP+1];
    cor_t  corc_reg [NSTEP+1];

    assign vc_reg[0]    = v3_reg;
    assign sidec_reg[0] = side3_reg;
    assign corc_reg[0]  = cor3_reg;

    for (genvar i = 0; i < NSTEP; i++) begin : g_iter
        cor_t cor_next;
        logic dir;

        // one micro-rotation, direction from z or from the sign of y
        always_comb begin
            dir = sidec_reg[i].rot ? (corc_reg[i].z >= 0) : (corc_reg[i].py < 0);
            if (dir) begin
                cor_next.px = corc_reg[i].px - (corc_reg[i].py >>> i);
                cor_next.py = corc_reg[i].py + (corc_reg[i].px >>> i);
                cor_next.z  = corc_reg[i].z - atan_q30(i);
            end else begin
                cor_next.px = corc_reg[i].px + (corc_reg[i].py >>> i);
                cor_next.py = corc_reg[i].py - (corc_reg[i].px >>> i);
                cor_next.z  = corc_reg[i].z + atan_q30(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[i+1] <= 1'b0;
            end else if (en) begin
                vc_reg[i+1] <= vc_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sidec_reg[i+1] <= sidec_reg[i];
                corc_reg[i+1]  <= cor_next;
            end
        end
    end

    // ----------------------------------------------------------- post stage 1
    logic               vp_reg;
    side_t              sidep_reg;
    logic signed [63:0] rxp_reg, ryp_reg;
    logic [59:0]        ph_reg;
    logic [31:0]        pl_reg;
    logic signed [ZW-1:0] zr_reg;

    logic signed [CW-1:0] fx, fy;
    logic [CW-1:0]        ux;
    logic signed [ZW-1:0] zr_next;
    logic [55:0]          lo_prod;

    // guard-bit rounding, angle rounding, gain products
    always_comb begin
        fx = (corc_reg[NSTEP].px + (CW'(1) <<< (GUARD - 1))) >>> GUARD;
        fy = (corc_reg[NSTEP].py + (CW'(1) <<< (GUARD - 1))) >>> GUARD;
        if (sidec_reg[NSTEP].flip) begin
            fx = -fx;
            fy = -fy;
        end
        ux      = corc_reg[NSTEP].px;
        lo_prod = 56'(ux[23:0]) * 56'(INV_GAIN);
        zr_next = (corc_reg[NSTEP].z + (ZW'(1) <<< (ZSH - 1))) >>> ZSH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= vc_reg[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sidep_reg <= sidec_reg[NSTEP];
            rxp_reg   <= 64'(fx);
            ryp_reg   <= 64'(fy);
            ph_reg    <= 60'(ux[CW-1:24]) * 60'(INV_GAIN);
            pl_reg    <= lo_prod[55:24];
            zr_reg    <= zr_next;
        end
    end

    // ------------------------------------------------------------ output stage
    logic               out_v_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        mag_reg;
    logic signed [24:0] ang_reg;
    logic               polar_reg, sat_reg, bad_reg;

    logic [60:0]        psum;
    logic [36:0]        mround;
    logic [32:0]        qx, qy;
    logic signed [31:0] x_next, y_next;
    logic [31:0]        mag_next;
    logic signed [24:0] ang_next;
    logic               sat_next;
    logic signed [ZW-1:0] zc;

    // final rounding, clipping and selection
    always_comb begin
        psum   = 61'(ph_reg) + 61'(pl_reg) + (61'(1) << 23);
        mround = psum[60:24];
        zc     = zr_reg;
        if (zc > D180) begin
            zc = D180;
        end else if (zc < -D180) begin
            zc = -D180;
        end
        qx       = sat32(rxp_reg);
        qy       = sat32(ryp_reg);
        x_next   = sidep_reg.x;
        y_next   = sidep_reg.y;
        sat_next = sidep_reg.sat;
        mag_next = (mround > 37'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : mround[31:0];
        ang_next = zc[24:0];
        if (sidep_reg.rot) begin
            x_next   = qx[31:0];
            y_next   = qy[31:0];
            sat_next = qx[32] | qy[32];
            mag_next = sidep_reg.mag;
            ang_next = sidep_reg.ang;
        end else if (sidep_reg.zero) begin
            mag_next = '0;
            ang_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            mag_reg   <= mag_next;
            ang_reg   <= ang_next;
            polar_reg <= sidep_reg.polar;
            sat_reg   <= sat_next;
            bad_reg   <= sidep_reg.bad;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_res_x      = x_reg;
    assign m_res_y      = y_reg;
    assign m_magnitude  = mag_reg;
    assign m_angle_deg  = ang_reg;
    assign m_polar_form = polar_reg;
    assign m_saturated  = sat_reg;
    assign m_bad_mode   = bad_reg;

    // ------------------------------------------------------------- assertions
    // an invalid mode leaves a zeroed result
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_mode |->
            m_res_x == '0 && m_res_y == '0 && m_magnitude == '0 && m_angle_deg == '0)
        else $error("bad mode result not zeroed");

    // a bad mode result carries neither the polar nor the saturated flag
    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_mode |-> !m_polar_form && !m_saturated)
        else $error("bad mode with other flags");

    // a stalled result stays in place
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_x) && $stable(m_magnitude))
        else $error("stalled result changed");

    // the zero vector has zero angle
    a_zero_ang: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_magnitude == '0 && !m_polar_form && m_res_x == '0 && m_res_y == '0
        |-> m_angle_deg == '0)
        else $error("zero vector with nonzero angle");

endmodule
